[src/rpd_pkg.sv]
// Shared types, byte codes and the hex digit decoder for the RSP packet deframer.
// No dependencies; rpd_csum_eval and the top level import this package.
package rpd_pkg;

  localparam logic [7:0] START_CHAR = 8'h24;  // '$'
  localparam logic [7:0] END_CHAR   = 8'h23;  // '#'
  localparam logic [7:0] ESC_CHAR   = 8'h7D;  // '}'
  localparam logic [7:0] ESC_XOR    = 8'h20;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_CSUM_HI,
    PH_CSUM_LO
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_RETRY,
    ST_BAD_NOACK,
    ST_BAD_HEX,
    ST_TRAIL_ESC
  } status_t;

  typedef enum logic [1:0] {
    ACK_NONE,
    ACK_PLUS,
    ACK_MINUS
  } ack_t;

  // Inputs of the end-of-packet check.
  typedef struct packed {
    logic [7:0] hi_char;
    logic [7:0] lo_char;
    logic [7:0] sum;
    logic       esc_at_end;
    logic       no_ack;
  } csum_ctx_t;

  // Verdict carried by the end record.
  typedef struct packed {
    status_t status;
    ack_t    ack;
  } end_info_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_t;

  // Decode one ASCII hex digit, either case.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.nib = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

[src/rpd_stream_if.sv]
// Valid/ready stream interfaces for the deframer's byte input and result output.
// Plain signals only; no package needed.
interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rpd_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] payload_byte;
  logic [2:0] packet_status;
  logic [1:0] ack_to_send;
  logic       packet_last;

  modport source (output valid, output out_kind, output payload_byte,
                  output packet_status, output ack_to_send, output packet_last,
                  input ready);
  modport sink   (input valid, input out_kind, input payload_byte,
                  input packet_status, input ack_to_send, input packet_last,
                  output ready);
endinterface

[src/rpd_csum_eval.sv]
// End-of-packet check: decodes the two checksum characters and grades the packet.
// Depends on rpd_pkg.
module rpd_csum_eval (
  input  rpd_pkg::csum_ctx_t ctx,
  output rpd_pkg::end_info_t info
);
  import rpd_pkg::*;

  hex_t hi_h;
  hex_t lo_h;

  assign hi_h = hex_decode(ctx.hi_char);
  assign lo_h = hex_decode(ctx.lo_char);

  always_comb begin
    if (hi_h.bad || lo_h.bad) begin
      info.status = ST_BAD_HEX;
      info.ack    = ACK_NONE;
    end else if ({hi_h.nib, lo_h.nib} != ctx.sum) begin
      info.status = ctx.no_ack ? ST_BAD_NOACK : ST_BAD_RETRY;
      info.ack    = ctx.no_ack ? ACK_NONE : ACK_MINUS;
    end else begin
      // checksum accepted: ack even when the body ended on a dangling escape
      info.status = ctx.esc_at_end ? ST_TRAIL_ESC : ST_OK;
      info.ack    = ctx.no_ack ? ACK_NONE : ACK_PLUS;
    end
  end

endmodule

[src/rsp_packet_deframer_top.sv]
// Top level of the RSP packet deframer: input stage, framing state, result register.
// Depends on rpd_pkg, rpd_stream_if.sv and rpd_csum_eval.
//
//   channel  | dir | handshake           | carries
//   ---------+-----+---------------------+------------------------------------------
//   in_ch    | in  | valid/ready         | rx_byte: one raw link byte per transfer
//   out_ch   | out | valid/ready         | payload byte or end record per transfer
//   cfg_*    | in  | cfg_we, no back-off | cfg_wdata: no_ack_mode
//
// One byte per cycle sustained while out_ch accepts results; a byte that makes a result
// goes from the input register through the framing logic into the result register,
// from which it transfers out.
// rst_n is synchronous, active low: framing returns to hunting for '$', no-ack
// mode clears and both stages empty. A stalled result holds only the byte behind
// it that would make a result; bytes that make none still drain.
module rsp_packet_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  rpd_in_if.sink     in_ch,
  rpd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import rpd_pkg::*;

  // configuration
  logic       no_ack_r;

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // framing state
  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       esc_pend_r, esc_pend_nxt;
  logic       esc_end_r, esc_end_nxt;
  logic [7:0] hi_char_r, hi_char_nxt;

  // result register
  logic       out_valid_r;
  logic       out_kind_r;
  logic [7:0] out_byte_r;
  logic [2:0] out_status_r;
  logic [1:0] out_ack_r;
  logic       out_last_r;

  // per-byte decisions
  logic       res_valid;
  logic       res_kind;
  logic [7:0] res_byte;
  logic       s1_adv;
  logic       out_free;

  csum_ctx_t  ctx;
  end_info_t  info;

  assign ctx.hi_char    = hi_char_r;
  assign ctx.lo_char    = s1_byte_r;
  assign ctx.sum        = sum_r;
  assign ctx.esc_at_end = esc_end_r;
  assign ctx.no_ack     = no_ack_r;

  rpd_csum_eval u_csum (
    .ctx  (ctx),
    .info (info)
  );

  // Advance the input byte when it makes no result or the result register frees up.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!res_valid || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HUNT: begin
        if (s1_byte_r == START_CHAR) phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        if (s1_byte_r == END_CHAR) phase_nxt = PH_CSUM_HI;
      end
      PH_CSUM_HI: phase_nxt = PH_CSUM_LO;
      PH_CSUM_LO: phase_nxt = PH_HUNT;
      default:    phase_nxt = PH_HUNT;
    endcase
  end

  // sum, escape tracking and result selection
  always_comb begin
    sum_nxt      = sum_r;
    esc_pend_nxt = esc_pend_r;
    esc_end_nxt  = esc_end_r;
    hi_char_nxt  = hi_char_r;
    res_valid    = 1'b0;
    res_kind     = KIND_PAYLOAD;
    res_byte     = s1_byte_r;
    case (phase_r)
      PH_HUNT: begin
        if (s1_byte_r == START_CHAR) begin
          sum_nxt      = 8'd0;
          esc_pend_nxt = 1'b0;
          esc_end_nxt  = 1'b0;
        end
      end
      PH_BODY: begin
        if (s1_byte_r == END_CHAR) begin
          // '#' closes the body even right after an escape
          esc_end_nxt  = esc_pend_r;
          esc_pend_nxt = 1'b0;
        end else begin
          sum_nxt = sum_r + s1_byte_r;
          if (esc_pend_r) begin
            esc_pend_nxt = 1'b0;
            res_valid    = 1'b1;
            res_byte     = s1_byte_r ^ ESC_XOR;
          end else if (s1_byte_r == ESC_CHAR) begin
            esc_pend_nxt = 1'b1;
          end else begin
            res_valid = 1'b1;
          end
        end
      end
      PH_CSUM_HI: hi_char_nxt = s1_byte_r;
      PH_CSUM_LO: begin
        esc_end_nxt = 1'b0;
        res_valid   = 1'b1;
        res_kind    = KIND_END;
        res_byte    = 8'd0;
      end
      default: ;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_ack_r <= 1'b0;
    end else if (cfg_we) begin
      no_ack_r <= cfg_wdata;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // framing state: update only when the held byte advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      sum_r      <= 8'd0;
      esc_pend_r <= 1'b0;
      esc_end_r  <= 1'b0;
    end else if (s1_adv) begin
      phase_r    <= phase_nxt;
      sum_r      <= sum_nxt;
      esc_pend_r <= esc_pend_nxt;
      esc_end_r  <= esc_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hi_char_r <= hi_char_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_kind_r   <= res_kind;
      out_byte_r   <= res_byte;
      out_status_r <= (res_kind == KIND_END) ? 3'(info.status) : 3'(ST_OK);
      out_ack_r    <= (res_kind == KIND_END) ? 2'(info.ack) : 2'(ACK_NONE);
      out_last_r   <= (res_kind == KIND_END);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_kind      = out_kind_r;
  assign out_ch.payload_byte  = out_byte_r;
  assign out_ch.packet_status = out_status_r;
  assign out_ch.ack_to_send   = out_ack_r;
  assign out_ch.packet_last   = out_last_r;

endmodule
